@@ design/roma_delta_kernel_eval_top_defines.svh @@
// assertion macros shared by the delta kernel design files
`ifndef ROMA_DELTA_KERNEL_EVAL_TOP_DEFINES_SVH
`define ROMA_DELTA_KERNEL_EVAL_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define RDKE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdke implication check failed");

// next-cycle implication, quiet during reset
`define RDKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdke next-cycle check failed");

`endif

@@ design/rdke_pkg.sv @@
// shared widths, constants and types of the delta kernel pipeline
`default_nettype none

package rdke_pkg;

  localparam int OFFSET_W = 20;
  localparam int WEIGHT_W = 16;

  // square root: radicand Q0.32 padded to an even width, root Q0.16 plus carry bit
  localparam int SQRT_RAD_W     = 34;
  localparam int SQRT_ROOT_W    = 17;
  localparam int SQRT_REM_W     = 20;
  localparam int SQRT_STEPS     = 17;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

  // outer branch numerator scaled to 2^16 units
  localparam int VSH_W    = 19;
  localparam int OUTER_W  = 20;
  localparam int QUOT_N_W = 18;

  // floor(n / 3) = (n * DIV3_MUL) >> DIV3_SHIFT, exact for n < 2^19
  localparam int                    DIV3_MUL_W = 19;
  localparam int                    DIV3_SHIFT = 20;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL   = 19'd349526;

  localparam logic [QUOT_N_W-1:0]    INNER_BIAS = 18'd65537;
  localparam logic [OUTER_W-1:0]     OUTER_BIAS = 20'd3;
  localparam logic [WEIGHT_W-1:0]    WEIGHT_MAX = 16'd43691;
  localparam logic [SQRT_ROOT_W-1:0] ROOT_MAX   = 17'd65536;

  typedef struct packed {
    logic             inner;
    logic             in_supp;
    logic [VSH_W-1:0] vsh;
  } side_t;

endpackage

`default_nettype wire

@@ design/rdke_if.sv @@
// valid/ready channel interfaces for offset items and weight items
`default_nettype none

interface rdke_in_if import rdke_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OFFSET_W-1:0] offset;

  modport source (output valid, output offset, input ready);
  modport sink   (input valid, input offset, output ready);
endinterface

interface rdke_out_if import rdke_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic                in_support;

  modport source (output valid, output weight, output in_support, input ready);
  modport sink   (input valid, input weight, input in_support, output ready);
endinterface

`default_nettype wire

@@ design/roma_delta_kernel_eval_top.sv @@
// three-point delta kernel evaluator, top level
//
//   channel  dir  payload                          handshake
//   in_i     in   offset  s20 Q3.16 (FRAC_BITS)    valid/ready
//   out_o    out  weight  u16 Q0.16, in_support    valid/ready
//
// one item per cycle sustained while the output takes items
// four front stages, nine root stages of two bits each (one in the last), two back stages
// every stage carries its own valid bit and loads only when the next one can take it
// a stalled output lets the pipeline fill up its empty stages before input stalls
// reset clears the valid bits only, the block keeps no state between items
`default_nettype none
`include "roma_delta_kernel_eval_top_defines.svh"

module roma_delta_kernel_eval_top import rdke_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rdke_in_if.sink    in_i,
  rdke_out_if.source out_o
);

  // front to root
  logic                   fr_valid, fr_ready;
  logic [SQRT_RAD_W-1:0]  fr_rad;
  side_t                  fr_side;

  // root to back end
  logic                   sq_valid, sq_ready;
  logic [SQRT_ROOT_W-1:0] sq_root;
  logic [SQRT_REM_W-1:0]  sq_rem;
  side_t                  sq_side;

  // magnitude, region test, branch distance, square and radicand
  rdke_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .offset_i (in_i.offset),
    .valid_o  (fr_valid),
    .ready_i  (fr_ready),
    .rad_o    (fr_rad),
    .side_o   (fr_side)
  );

  // square root of the Q0.32 radicand, flags and numerator ride alongside
  rdke_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .ready_i (sq_ready),
    .root_o  (sq_root),
    .rem_o   (sq_rem),
    .side_o  (sq_side)
  );

  // rounding, constant division and the output register
  rdke_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (sq_valid),
    .ready_o      (sq_ready),
    .root_i       (sq_root),
    .rem_i        (sq_rem),
    .side_i       (sq_side),
    .valid_o      (out_o.valid),
    .ready_i      (out_o.ready),
    .weight_o     (out_o.weight),
    .in_support_o (out_o.in_support)
  );

  // outside the support the weight is zero
  `RDKE_ASSERT_IMP(a_zero_outside, clk_i, rst_ni, out_o.valid && !out_o.in_support, out_o.weight == '0)
  // the kernel peaks at the origin
  `RDKE_ASSERT_IMP(a_weight_peak, clk_i, rst_ni, out_o.valid, out_o.weight <= WEIGHT_MAX)
  // with the sink taking items the whole chain is open
  `RDKE_ASSERT_IMP(a_ready_chain, clk_i, rst_ni, out_o.ready, in_i.ready)

endmodule

`default_nettype wire

@@ design/rdke_front.sv @@
// front stages: magnitude and region, branch distance, square, radicand
`default_nettype none

module rdke_front import rdke_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic signed [OFFSET_W-1:0] offset_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [SQRT_RAD_W-1:0]      rad_o,
  output side_t                      side_o
);

  localparam int CW    = (FRAC_BITS + 2 > OFFSET_W + 1) ? FRAC_BITS + 2 : OFFSET_W + 1;
  localparam int UW    = (FRAC_BITS < OFFSET_W) ? FRAC_BITS : OFFSET_W;
  localparam int VW    = CW + 1;
  localparam int VEW   = VW + 16;
  localparam int VSHL  = (FRAC_BITS <= 16) ? 16 - FRAC_BITS : 0;
  localparam int VSHR  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int DW    = 2 * FRAC_BITS + 1;
  localparam int TW    = 2 * UW + 2;
  localparam int EW    = DW + 32;
  localparam int QSHL  = (FRAC_BITS <= 16) ? 32 - 2 * FRAC_BITS : 0;
  localparam int QSHR  = (FRAC_BITS > 16) ? 2 * FRAC_BITS - 32 : 0;

  localparam logic [CW-1:0] ONE_C   = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] HALF_C  = CW'(1) << (FRAC_BITS - 1);
  localparam logic [CW-1:0] LIMIT_C = CW'(3) << (FRAC_BITS - 1);
  localparam logic [VW-1:0] FIVE_C  = VW'(5) << FRAC_BITS;
  localparam logic [DW-1:0] ONE2_C  = DW'(1) << (2 * FRAC_BITS);

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: magnitude and region
  logic [OFFSET_W-1:0] mag;
  logic [CW-1:0]       mag_ext;
  logic                inner_d, inside_d;
  logic [OFFSET_W-1:0] s1_a_q;
  logic                s1_inner_q, s1_inside_q;

  assign mag      = offset_i[OFFSET_W-1] ? (~$unsigned(offset_i) + 1'b1) : $unsigned(offset_i);
  assign mag_ext  = CW'(mag);
  assign inner_d  = (mag_ext <= HALF_C);
  assign inside_d = (mag_ext <= LIMIT_C);

  // stage 2: distance to the branch centre and the scaled outer numerator
  logic [CW-1:0]  a_ext, u_full;
  logic [UW-1:0]  u_d, s2_u_q;
  logic [VW-1:0]  v;
  logic [VEW-1:0] v_ext;
  side_t          s2_side_d, s2_side_q;

  assign a_ext  = CW'(s1_a_q);
  assign u_full = s1_inner_q ? a_ext :
                  ((a_ext >= ONE_C) ? (a_ext - ONE_C) : (ONE_C - a_ext));
  assign u_d    = u_full[UW-1:0];
  assign v      = FIVE_C - ((VW'(a_ext) << 1) + VW'(a_ext));
  assign v_ext  = (VEW'(v) << VSHL) >> VSHR;

  always_comb begin
    s2_side_d.inner   = s1_inner_q;
    s2_side_d.in_supp = s1_inside_q;
    s2_side_d.vsh     = v_ext[VSH_W-1:0];
  end

  // stage 3: square
  logic [2*UW-1:0] u2_d, s3_u2_q;
  side_t           s3_side_q;

  assign u2_d = s2_u_q * s2_u_q;

  // stage 4: radicand 1 - 3u^2 brought to Q0.32
  logic [TW-1:0]         tu;
  logic [DW-1:0]         d;
  logic [EW-1:0]         r_ext;
  logic [SQRT_RAD_W-1:0] s4_rad_q;
  side_t                 s4_side_q;

  assign tu    = (TW'(s3_u2_q) << 1) + TW'(s3_u2_q);
  assign d     = ONE2_C - DW'(tu);
  assign r_ext = (EW'(d) << QSHL) >> QSHR;

  // bubble-collapsing ready chain
  assign rdy4    = !s4_v_q || ready_i;
  assign rdy3    = !s3_v_q || rdy4;
  assign rdy2    = !s2_v_q || rdy3;
  assign rdy1    = !s1_v_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= valid_i;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy3) s3_v_q <= s2_v_q;
      if (rdy4) s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      s1_a_q      <= mag;
      s1_inner_q  <= inner_d;
      s1_inside_q <= inside_d;
    end
    if (rdy2 && s1_v_q) begin
      s2_u_q    <= u_d;
      s2_side_q <= s2_side_d;
    end
    if (rdy3 && s2_v_q) begin
      s3_u2_q   <= u2_d;
      s3_side_q <= s2_side_q;
    end
    if (rdy4 && s3_v_q) begin
      s4_rad_q  <= r_ext[SQRT_RAD_W-1:0];
      s4_side_q <= s3_side_q;
    end
  end

  assign valid_o = s4_v_q;
  assign rad_o   = s4_rad_q;
  assign side_o  = s4_side_q;

endmodule

`default_nettype wire

@@ design/rdke_sqrt.sv @@
// pipelined digit-by-digit square root, two result bits per stage, one in the last
`default_nettype none
`include "roma_delta_kernel_eval_top_defines.svh"

module rdke_sqrt import rdke_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [SQRT_RAD_W-1:0]  rad_i,
  input  side_t                  side_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [SQRT_ROOT_W-1:0] root_o,
  output logic [SQRT_REM_W-1:0]  rem_o,
  output side_t                  side_o
);

  logic                   v_q    [SQRT_STAGES];
  logic [SQRT_RAD_W-1:0]  rad_q  [SQRT_STAGES];
  logic [SQRT_ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [SQRT_REM_W-1:0]  rem_q  [SQRT_STAGES];
  side_t                  side_q [SQRT_STAGES];
  logic                   rdy    [SQRT_STAGES+1];

  assign rdy[SQRT_STAGES] = ready_i;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    localparam int LEFT  = SQRT_STEPS - g * SQRT_PER_STAGE;
    localparam int NSTEP = (LEFT < SQRT_PER_STAGE) ? LEFT : SQRT_PER_STAGE;

    logic                   vin;
    logic [SQRT_RAD_W-1:0]  rad_in, rad_d;
    logic [SQRT_ROOT_W-1:0] root_in, root_d;
    logic [SQRT_REM_W-1:0]  rem_in, rem_d;
    side_t                  side_in;

    if (g == 0) begin : g_first
      assign vin     = valid_i;
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = v_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign root_in = root_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin : p_step
      logic [SQRT_REM_W-1:0] rem_s;
      logic [SQRT_REM_W-1:0] trial;
      rad_d  = rad_in;
      root_d = root_in;
      rem_d  = rem_in;
      rem_s  = '0;
      trial  = '0;
      for (int i = 0; i < NSTEP; i++) begin
        rem_s = (rem_d << 2) | SQRT_REM_W'(rad_d[SQRT_RAD_W-1 -: 2]);
        trial = (SQRT_REM_W'(root_d) << 2) | SQRT_REM_W'(1);
        if (rem_s >= trial) begin
          rem_d  = rem_s - trial;
          root_d = (root_d << 1) | SQRT_ROOT_W'(1);
        end else begin
          rem_d  = rem_s;
          root_d = root_d << 1;
        end
        rad_d = rad_d << 2;
      end
    end

    assign rdy[g] = !v_q[g] || rdy[g+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[g] && vin) begin
        rad_q[g]  <= rad_d;
        root_q[g] <= root_d;
        rem_q[g]  <= rem_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[SQRT_STAGES-1];
  assign root_o  = root_q[SQRT_STAGES-1];
  assign rem_o   = rem_q[SQRT_STAGES-1];
  assign side_o  = side_q[SQRT_STAGES-1];

  // remainder of a finished root never exceeds twice the root
  `RDKE_ASSERT_IMP(a_sqrt_rem_bound, clk_i, rst_ni, valid_o, rem_o <= (SQRT_REM_W'(root_o) << 1))
  // inside the support the radicand is at most 2^32, so the root is at most 2^16
  `RDKE_ASSERT_IMP(a_sqrt_root_max, clk_i, rst_ni, valid_o && side_o.in_supp, root_o <= ROOT_MAX)
  // a held last stage keeps its root
  `RDKE_ASSERT_NEXT(a_sqrt_hold, clk_i, rst_ni, valid_o && !ready_i, valid_o && $stable(root_o))

endmodule

`default_nettype wire

@@ design/rdke_post.sv @@
// back stages: root rounding, branch numerator, divide by three, output register
`default_nettype none

module rdke_post import rdke_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [SQRT_ROOT_W-1:0] root_i,
  input  logic [SQRT_REM_W-1:0]  rem_i,
  input  side_t                  side_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [WEIGHT_W-1:0]    weight_o,
  output logic                   in_support_o
);

  localparam int PROD_W = QUOT_N_W + DIV3_MUL_W;

  logic                   a_v_q, b_v_q;
  logic                   rdy_a, rdy_b;
  logic [SQRT_ROOT_W-1:0] s;
  logic [OUTER_W-1:0]     w;
  logic [QUOT_N_W-1:0]    n_d, a_n_q;
  logic                   zero_d, a_zero_q, a_inside_q;
  logic [PROD_W-1:0]      prod;
  logic [WEIGHT_W-1:0]    weight_d, b_weight_q;
  logic                   b_inside_q;

  // nearest-integer root, then the numerator to be divided by three
  assign s      = root_i + SQRT_ROOT_W'(rem_i > SQRT_REM_W'(root_i));
  assign w      = OUTER_W'(side_i.vsh) + OUTER_BIAS - OUTER_W'(s);
  assign n_d    = side_i.inner ? (QUOT_N_W'(s) + INNER_BIAS) : w[QUOT_N_W:1];
  // outside the support, or with an outer numerator below zero, the weight clamps to zero
  assign zero_d = !side_i.in_supp || (!side_i.inner && w[OUTER_W-1]);

  assign prod     = PROD_W'(a_n_q) * PROD_W'(DIV3_MUL);
  assign weight_d = a_zero_q ? '0 : prod[DIV3_SHIFT +: WEIGHT_W];

  assign rdy_b   = !b_v_q || ready_i;
  assign rdy_a   = !a_v_q || rdy_b;
  assign ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (rdy_a) a_v_q <= valid_i;
      if (rdy_b) b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      a_n_q      <= n_d;
      a_zero_q   <= zero_d;
      a_inside_q <= side_i.in_supp;
    end
    if (rdy_b && a_v_q) begin
      b_weight_q <= weight_d;
      b_inside_q <= a_inside_q;
    end
  end

  assign valid_o      = b_v_q;
  assign weight_o     = b_weight_q;
  assign in_support_o = b_inside_q;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for the three-point delta kernel evaluator
`timescale 1ns / 1ps

module tb;
  import rdke_pkg::*;

  // fixed-point setup of the block under test
  localparam int FRAC_BITS = 16;
  localparam longint UNIT = longint'(1) << FRAC_BITS;      // r = 1.0
  localparam longint HALF_UNIT = UNIT >> 1;                // r = 0.5
  localparam longint SUPPORT_EDGE = 3 * HALF_UNIT;         // r = 1.5

  // pipeline depth from input to result, margin on top for the final drain
  localparam int LATENCY = 15;
  localparam int DRAIN_CYCLES = 4 * LATENCY;
  // cycles with no item moving on either side before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // long receiver hold-off used to fill the pipeline and back up the input
  localparam int HOLD_CYCLES = 200;

  localparam int BURST_ITEMS = 400;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                in_support;
  } kernel_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rdke_in_if  offset_ch ();
  rdke_out_if weight_ch ();

  roma_delta_kernel_eval_top #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (offset_ch),
    .out_o (weight_ch)
  );

  always #5 clk_i = ~clk_i;

  // weights still owed by the block, oldest first
  kernel_out_t pending_weights[$];
  int          error_cnt = 0;

  // idling controls, percent of cycles
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  // hold-off handshake between the test sequence and the receiver process
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // kernel predictor
  // ---------------------------------------------------------------------------

  // square root of a Q0.32 radicand, rounded to the nearest Q0.16 value
  function automatic longint nearest_root(input longint rad);
    longint root;
    longint trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= rad) root = trial;
    end
    // round up when the remainder exceeds the root, ties cannot arise
    if (rad - root * root > root) root = root + 1;
    return root;
  endfunction

  // radicand 1 - 3u^2 in Q0.2F, brought to Q0.32
  function automatic longint radicand_q32(input longint u);
    longint rad;
    rad = UNIT * UNIT - 3 * u * u;
    if (FRAC_BITS <= 16) return rad << (32 - 2 * FRAC_BITS);
    return rad >> (2 * FRAC_BITS - 32);
  endfunction

  function automatic kernel_out_t kernel_weight(input logic signed [OFFSET_W-1:0] offset);
    kernel_out_t res;
    longint      mag;
    longint      u;
    longint      root;
    longint      num;
    longint      quo;
    // sign-extended first, so the most negative offset keeps its full magnitude
    mag = longint'(offset);
    if (mag < 0) mag = -mag;
    res.weight = '0;
    res.in_support = 1'b0;
    if (mag <= HALF_UNIT) begin
      // central branch: (1 + sqrt(1 - 3r^2)) / 3, rounded
      root = nearest_root(radicand_q32(mag));
      res.weight = WEIGHT_W'((65536 + root + 1) / 3);
      res.in_support = 1'b1;
    end else if (mag <= SUPPORT_EDGE) begin
      // outer branch: (5 - 3|r| - sqrt(1 - 3(1-|r|)^2)) / 6, rounded half up
      u = (mag >= UNIT) ? mag - UNIT : UNIT - mag;
      root = nearest_root(radicand_q32(u));
      num = (5 * UNIT - 3 * mag) * 65536 - root * UNIT;
      quo = (num + 3 * UNIT) / (6 * UNIT);
      // rounding of the root can push it just below zero near r = 1.5
      res.weight = (quo < 0) ? '0 : WEIGHT_W'(quo);
      res.in_support = 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      weight_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      weight_ch.ready <= 1'b0;
    end else begin
      weight_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_cnt++;
  endtask

  always @(posedge clk_i) begin
    kernel_out_t want;
    if (rst_ni && weight_ch.valid && weight_ch.ready) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("unexpected weight item", weight_ch.weight, -1);
      end else begin
        want = pending_weights.pop_front();
        if (weight_ch.weight !== want.weight)
          report_mismatch("weight", weight_ch.weight, want.weight);
        if (weight_ch.in_support !== want.in_support)
          report_mismatch("in_support", weight_ch.in_support, want.in_support);
      end
    end
  end

  // watchdog: counts cycles in which no item moves on either channel
  always @(posedge clk_i) begin
    if ((offset_ch.valid && offset_ch.ready) || (weight_ch.valid && weight_ch.ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one offset item; valid stays high into the next call unless an idle gap comes
  task automatic send_offset(input logic signed [OFFSET_W-1:0] offset);
    while ($urandom_range(99) < src_idle_pct) begin
      offset_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    offset_ch.valid <= 1'b1;
    offset_ch.offset <= offset;
    do @(posedge clk_i); while (!offset_ch.ready);
    pending_weights.push_back(kernel_weight(offset));
  endtask

  // stop offering and wait for every owed weight
  task automatic wait_drain();
    offset_ch.valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk_i);
  endtask

  // mostly inside the support, some around r = 0.5, 1.0 and 1.5, the rest anywhere
  function automatic logic signed [OFFSET_W-1:0] pick_offset();
    int          sel;
    int unsigned mag;
    logic signed [OFFSET_W-1:0] val;
    sel = $urandom_range(99);
    if (sel < 70) begin
      mag = $urandom_range(int'(SUPPORT_EDGE) + 2048, 0);
    end else if (sel < 85) begin
      case ($urandom_range(2))
        0: mag = int'(HALF_UNIT) + $urandom_range(8) - 4;
        1: mag = int'(UNIT) + $urandom_range(8) - 4;
        default: mag = int'(SUPPORT_EDGE) + $urandom_range(64) - 32;
      endcase
    end else begin
      return OFFSET_W'($urandom);
    end
    val = OFFSET_W'(mag);
    return $urandom_range(1) ? -val : val;
  endfunction

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++) send_offset(pick_offset());
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, branch edges and the special cases
  task automatic test_directed();
    logic signed [OFFSET_W-1:0] offsets[$];
    offsets = '{
      20'sd0, 20'sd1, -20'sd1,                       // kernel peak and its neighbours
      20'sd16384, 20'sd32767,
      20'sd32768, -20'sd32768,                       // |r| = 0.5 uses the central formula
      20'sd32769, -20'sd32769,
      20'sd65535, 20'sd65536, -20'sd65536,           // |r| = 1.0, zero-width radicand term
      20'sd98303, 20'sd98304, -20'sd98304,           // |r| = 1.5 still inside, weight zero
      20'sd98305, -20'sd98305,                       // just outside the support
      20'sd131072,
      20'sd524287,                                   // largest positive offset
      -20'sd524288, -20'sd524287,                    // most negative, magnitude taken exactly
      20'h55555, 20'hAAAAA                           // alternating bit patterns
    };
    sink_stall_pct = 0;
    src_idle_pct = 0;
    foreach (offsets[i]) send_offset(offsets[i]);
    wait_drain();
  endtask

  task automatic test_streaming();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    random_burst(BURST_ITEMS);
  endtask

  task automatic test_sender_gaps();
    src_idle_pct = 65;
    sink_stall_pct = 0;
    random_burst(BURST_ITEMS);
  endtask

  task automatic test_receiver_stalls();
    src_idle_pct = 0;
    sink_stall_pct = 65;
    random_burst(BURST_ITEMS);
  endtask

  task automatic test_both_idle();
    src_idle_pct = 15;
    sink_stall_pct = 15;
    random_burst(BURST_ITEMS);
  endtask

  // receiver holds off while items keep coming, so the pipeline fills and
  // input ready drops; afterwards the sender waits for a full drain
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 48; i++) send_offset(pick_offset());
    wait_drain();
  endtask

  initial begin
    offset_ch.valid = 1'b0;
    offset_ch.offset = '0;
    weight_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();

    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/rdke_pkg.sv
design/rdke_if.sv
design/rdke_front.sv
design/rdke_sqrt.sv
design/rdke_post.sv
design/roma_delta_kernel_eval_top.sv
sim/tb.sv
